/* design/knob_button_setpoint_menu_controller_macros.svh */
// ----------------------------------------------------------------------------
// Knob and button controller assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef KNOB_BUTTON_SETPOINT_MENU_CONTROLLER_MACROS_SVH
`define KNOB_BUTTON_SETPOINT_MENU_CONTROLLER_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define KBSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define KBSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define KBSM_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/kbsm_pkg.sv */
// ----------------------------------------------------------------------------
// kbsm_pkg
// Types, reset values, constants and helpers for the knob and button controller.
// ----------------------------------------------------------------------------
`default_nettype none

package kbsm_pkg;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_MS    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_MS  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT_MAX   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENCODER_NEGATE = 8'd3;

    // Register reset values
    localparam logic [9:0]  DEBOUNCE_MS_RST    = 10'd30;
    localparam logic [15:0] LONG_PRESS_MS_RST  = 16'd600;
    localparam logic [13:0] SETPOINT_MAX_RST   = 14'd3000;
    localparam logic        ENCODER_NEGATE_RST = 1'b1;

    // State reset values
    localparam logic [13:0] SETPOINT_RST = 14'd1250;
    localparam logic [1:0]  CURSOR_RST   = 2'd3;

    // Menu sizes
    localparam int unsigned MENU_ENTRIES_DEF = 4;
    localparam int unsigned SUBMENU_ROWS_DEF = 4;

    // Detent counts beyond this are saturated to it before scaling
    localparam logic signed [14:0] STEP_SAT = 15'sd10000;

    // Setpoint step of each cursor digit: tens, ones, tenths, hundredths
    localparam logic [10:0] DIGIT_WEIGHT [4] = '{11'd1000, 11'd100, 11'd10, 11'd1};

    // Event queue
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PG_READOUT  = 2'd0,
        PG_OVERVIEW = 2'd1,
        PG_SUBLIST  = 2'd2
    } t_page;

    // One classified poll, front to back
    typedef struct packed {
        logic                short_press;
        logic                long_press;
        logic                level;
        logic signed [30:0]  steps;
        logic signed [14:0]  sat_steps;
        logic [3:0]          ov_res;
        logic [3:0]          row_res;
    } t_event;

    // Residue of a signed detent count modulo a small constant n (1..16).
    // Sum per-bit residues of the weights, then fold with shifted copies of n.
    function automatic logic [3:0] step_residue(input logic [30:0] steps,
                                                input int unsigned n);
        logic [12:0] acc;
        logic [12:0] lim;
        logic [4:0]  nn;
        logic [4:0]  w;
        logic [4:0]  w_neg;
        nn  = 5'(n);
        acc = '0;
        w   = (nn == 5'd1) ? 5'd0 : 5'd1;
        for (int i = 0; i < 30; i++) begin
            if (steps[i]) begin
                acc = acc + 13'(w);
            end
            w = w << 1;
            if (w >= nn) begin
                w = w - nn;
            end
        end
        // sign bit carries weight -2^30
        w_neg = (w == 5'd0) ? 5'd0 : (nn - w);
        if (steps[30]) begin
            acc = acc + 13'(w_neg);
        end
        for (int k = 8; k >= 0; k--) begin
            lim = 13'(nn) << k;
            if (acc >= lim) begin
                acc = acc - lim;
            end
        end
        return acc[3:0];
    endfunction

endpackage

`default_nettype wire

/* design/knob_button_setpoint_menu_controller.sv */
// ----------------------------------------------------------------------------
// knob_button_setpoint_menu_controller
// Rotary knob and long-press button front end for a setpoint and menu display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one poll per request: the
//   millisecond time, the raw button level and the raw quadrature count.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   request per poll, in order: page, cursor, setpoint, highlights, the press
//   flags of this poll, the detents applied and the debounced button level.
//   Config channel (i_cfg_valid / o_cfg_ready) writes one register per request;
//   o_cfg_ready is always high and unknown indexes are dropped. Write only
//   while no poll is in flight.
//   A poll passes through the intake register, the event queue and the result
//   register, in that order.
//   Throughput: one poll per cycle while the result side does not stall; the
//   queue lets intake and menu engine move apart.
//   Reset (synchronous, active low) restores register defaults, returns to
//   the main page on the hundredths digit at 12.50 V and empties the queue.
//   A stalled result is held; the queue and the intake register then take up
//   to three more polls before o_in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module knob_button_setpoint_menu_controller #(
    parameter int unsigned MENU_ENTRIES = kbsm_pkg::MENU_ENTRIES_DEF,
    parameter int unsigned SUBMENU_ROWS = kbsm_pkg::SUBMENU_ROWS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // poll requests
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [31:0]                         i_now_ms,
    input  wire logic                                i_button_pressed,
    input  wire logic signed [31:0]                  i_encoder_count,
    // result requests
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_page,
    output logic [1:0]                               o_digit_cursor,
    output logic [13:0]                              o_setpoint_cv,
    output logic [1:0]                               o_overview_sel,
    output logic [1:0]                               o_open_submenu,
    output logic [1:0]                               o_submenu_row,
    output logic                                     o_short_press,
    output logic                                     o_long_press,
    output logic signed [30:0]                       o_detent_steps,
    output logic                                     o_button_debounced,
    // register writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [kbsm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [kbsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [9:0]  r_debounce_ms;
    logic [15:0] r_long_press_ms;
    logic [13:0] r_setpoint_max;
    logic        r_encoder_negate;

    // Intake to queue, queue to engine
    logic             front_valid, front_ready;
    kbsm_pkg::t_event front_ev;
    logic             back_valid, back_ready;
    kbsm_pkg::t_event back_ev;

    assign o_cfg_ready = 1'b1;

    // Take a write at once; drop indexes beyond the register list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= kbsm_pkg::DEBOUNCE_MS_RST;
            r_long_press_ms  <= kbsm_pkg::LONG_PRESS_MS_RST;
            r_setpoint_max   <= kbsm_pkg::SETPOINT_MAX_RST;
            r_encoder_negate <= kbsm_pkg::ENCODER_NEGATE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kbsm_pkg::CFG_DEBOUNCE_MS:    r_debounce_ms    <= i_cfg_data[9:0];
                kbsm_pkg::CFG_LONG_PRESS_MS:  r_long_press_ms  <= i_cfg_data[15:0];
                kbsm_pkg::CFG_SETPOINT_MAX:   r_setpoint_max   <= i_cfg_data[13:0];
                kbsm_pkg::CFG_ENCODER_NEGATE: r_encoder_negate <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Intake: debounce, hold timing, detents; classify into events
    kbsm_front #(
        .MENU_ENTRIES (MENU_ENTRIES),
        .SUBMENU_ROWS (SUBMENU_ROWS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_now_ms         (i_now_ms),
        .i_button_pressed (i_button_pressed),
        .i_encoder_count  (i_encoder_count),
        .i_debounce_ms    (r_debounce_ms),
        .i_long_press_ms  (r_long_press_ms),
        .i_encoder_negate (r_encoder_negate),
        .o_ev_valid       (front_valid),
        .i_ev_ready       (front_ready),
        .o_ev             (front_ev)
    );

    // Decouple intake from the engine
    kbsm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_ev),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_ev)
    );

    // Engine: apply press then rotation, hold the result register
    kbsm_back #(
        .MENU_ENTRIES (MENU_ENTRIES),
        .SUBMENU_ROWS (SUBMENU_ROWS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ev_valid         (back_valid),
        .o_ev_ready         (back_ready),
        .i_ev               (back_ev),
        .i_setpoint_max     (r_setpoint_max),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_page             (o_page),
        .o_digit_cursor     (o_digit_cursor),
        .o_setpoint_cv      (o_setpoint_cv),
        .o_overview_sel     (o_overview_sel),
        .o_open_submenu     (o_open_submenu),
        .o_submenu_row      (o_submenu_row),
        .o_short_press      (o_short_press),
        .o_long_press       (o_long_press),
        .o_detent_steps     (o_detent_steps),
        .o_button_debounced (o_button_debounced)
    );

endmodule

`default_nettype wire

/* design/kbsm_front.sv */
// ----------------------------------------------------------------------------
// kbsm_front
// Poll intake: button debounce and long-press timing, detent accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsm_front #(
    parameter int unsigned MENU_ENTRIES = kbsm_pkg::MENU_ENTRIES_DEF,
    parameter int unsigned SUBMENU_ROWS = kbsm_pkg::SUBMENU_ROWS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic               i_button_pressed,
    input  wire logic signed [31:0] i_encoder_count,
    input  wire logic [9:0]         i_debounce_ms,
    input  wire logic [15:0]        i_long_press_ms,
    input  wire logic               i_encoder_negate,
    output logic                    o_ev_valid,
    input  wire logic               i_ev_ready,
    output kbsm_pkg::t_event        o_ev
);

    logic               r_level, n_level;
    logic [31:0]        r_last_edge, n_last_edge;
    logic [31:0]        r_press_start, n_press_start;
    logic               r_long_done, n_long_done;
    logic [31:0]        r_prev_count;
    logic signed [2:0]  r_rem, n_rem;
    logic               r_ev_valid;
    logic               r_short, r_long, r_ev_level;
    logic signed [30:0] r_steps;

    logic               accept;
    logic [31:0]        edge_age, hold_age;
    logic               edge_take, long_mid, short_hit, long_hit;
    logic [31:0]        diff;
    logic signed [32:0] delta;
    logic signed [33:0] sum, sum_bias, quo, rem_full;

    assign o_in_stall = r_ev_valid && !i_ev_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // Button: edge lockout, then hold timing against the updated press start
    always_comb begin
        edge_age      = i_now_ms - r_last_edge;
        edge_take     = (i_button_pressed != r_level) && (edge_age > 32'(i_debounce_ms));
        n_level       = edge_take ? i_button_pressed : r_level;
        n_last_edge   = edge_take ? i_now_ms : r_last_edge;
        n_press_start = (edge_take && i_button_pressed) ? i_now_ms : r_press_start;
        long_mid      = (edge_take && i_button_pressed) ? 1'b0 : r_long_done;
        short_hit     = edge_take && !i_button_pressed && !r_long_done;
        hold_age      = i_now_ms - n_press_start;
        long_hit      = n_level && !long_mid && (hold_age >= 32'(i_long_press_ms));
        n_long_done   = long_mid || long_hit;
    end

    // Encoder: signed delta, remainder kept, divide by four toward zero
    always_comb begin
        diff     = i_encoder_count - r_prev_count;
        delta    = {diff[31], diff};
        if (i_encoder_negate) begin
            delta = -delta;
        end
        sum      = 34'(delta) + 34'(r_rem);
        sum_bias = sum + (sum[33] ? 34'sd3 : 34'sd0);
        quo      = sum_bias >>> 2;
        rem_full = sum - (quo <<< 2);
        n_rem    = rem_full[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= 1'b0;
            r_last_edge   <= '0;
            r_press_start <= '0;
            r_long_done   <= 1'b0;
            r_prev_count  <= '0;
            r_rem         <= '0;
            r_ev_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_level       <= n_level;
                r_last_edge   <= n_last_edge;
                r_press_start <= n_press_start;
                r_long_done   <= n_long_done;
                r_prev_count  <= i_encoder_count;
                r_rem         <= n_rem;
                r_ev_valid    <= 1'b1;
            end else if (i_ev_ready) begin
                r_ev_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_short    <= short_hit;
            r_long     <= long_hit;
            r_ev_level <= n_level;
            r_steps    <= quo[30:0];
        end
    end

    // Classify: saturated steps for the setpoint, residues for the menus
    always_comb begin
        o_ev.short_press = r_short;
        o_ev.long_press  = r_long;
        o_ev.level       = r_ev_level;
        o_ev.steps       = r_steps;
        if (r_steps > 31'(kbsm_pkg::STEP_SAT)) begin
            o_ev.sat_steps = kbsm_pkg::STEP_SAT;
        end else if (r_steps < -31'(kbsm_pkg::STEP_SAT)) begin
            o_ev.sat_steps = -kbsm_pkg::STEP_SAT;
        end else begin
            o_ev.sat_steps = r_steps[14:0];
        end
        o_ev.ov_res  = kbsm_pkg::step_residue(r_steps, MENU_ENTRIES);
        o_ev.row_res = kbsm_pkg::step_residue(r_steps, SUBMENU_ROWS);
    end

    assign o_ev_valid = r_ev_valid;

endmodule

`default_nettype wire

/* design/kbsm_queue.sv */
// ----------------------------------------------------------------------------
// kbsm_queue
// Short event queue between the intake and the menu engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire kbsm_pkg::t_event i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output kbsm_pkg::t_event      o_pop_data
);

    localparam int unsigned PTR_W = $clog2(kbsm_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(kbsm_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(kbsm_pkg::QUEUE_DEPTH);

    kbsm_pkg::t_event r_q [kbsm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != FULL);
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* design/kbsm_back.sv */
// ----------------------------------------------------------------------------
// kbsm_back
// Menu engine: page machine, digit cursor, setpoint and highlights.
// ----------------------------------------------------------------------------
`default_nettype none

module kbsm_back #(
    parameter int unsigned MENU_ENTRIES = kbsm_pkg::MENU_ENTRIES_DEF,
    parameter int unsigned SUBMENU_ROWS = kbsm_pkg::SUBMENU_ROWS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_ev_valid,
    output logic                    o_ev_ready,
    input  wire kbsm_pkg::t_event   i_ev,
    input  wire logic [13:0]        i_setpoint_max,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_page,
    output logic [1:0]              o_digit_cursor,
    output logic [13:0]             o_setpoint_cv,
    output logic [1:0]              o_overview_sel,
    output logic [1:0]              o_open_submenu,
    output logic [1:0]              o_submenu_row,
    output logic                    o_short_press,
    output logic                    o_long_press,
    output logic signed [30:0]      o_detent_steps,
    output logic                    o_button_debounced
);

    localparam logic [4:0] MENU_N = 5'(MENU_ENTRIES);
    localparam logic [4:0] ROWS_N = 5'(SUBMENU_ROWS);

    kbsm_pkg::t_page    r_page, n_page;
    logic [1:0]         r_cursor, n_cursor;
    logic [13:0]        r_setpoint, n_setpoint;
    logic [3:0]         r_ov, n_ov;
    logic [3:0]         r_sub, n_sub;
    logic [3:0]         r_row, n_row;
    logic               r_out_valid;
    logic               r_short, r_long, r_level;
    logic signed [30:0] r_steps;

    logic               pop;
    logic signed [26:0] sp_prod;
    logic signed [27:0] sp_sum;
    logic [4:0]         ov_sum, row_sum;

    assign o_ev_ready = !r_out_valid || !i_out_stall;
    assign pop        = i_ev_valid && o_ev_ready;

    // Button first, rotation after, as one poll
    always_comb begin
        n_page     = r_page;
        n_cursor   = r_cursor;
        n_setpoint = r_setpoint;
        n_ov       = r_ov;
        n_sub      = r_sub;
        n_row      = r_row;
        sp_prod    = '0;
        sp_sum     = '0;
        ov_sum     = '0;
        row_sum    = '0;

        if (i_ev.short_press) begin
            unique case (n_page)
                kbsm_pkg::PG_READOUT: begin
                    n_cursor = n_cursor + 2'd1;
                end
                kbsm_pkg::PG_OVERVIEW: begin
                    n_sub  = n_ov;
                    n_row  = '0;
                    n_page = kbsm_pkg::PG_SUBLIST;
                end
                default: begin
                end
            endcase
        end

        if (i_ev.long_press) begin
            unique case (n_page)
                kbsm_pkg::PG_READOUT: begin
                    n_ov   = '0;
                    n_page = kbsm_pkg::PG_OVERVIEW;
                end
                kbsm_pkg::PG_OVERVIEW: begin
                    n_page = kbsm_pkg::PG_READOUT;
                end
                default: begin
                    n_page = kbsm_pkg::PG_OVERVIEW;
                end
            endcase
        end

        if (i_ev.steps != '0) begin
            unique case (n_page)
                kbsm_pkg::PG_READOUT: begin
                    sp_prod = 27'(i_ev.sat_steps)
                            * 27'($signed({1'b0, kbsm_pkg::DIGIT_WEIGHT[n_cursor]}));
                    sp_sum  = 28'($signed({1'b0, n_setpoint})) + 28'(sp_prod);
                    if (sp_sum[27]) begin
                        n_setpoint = '0;
                    end else if (sp_sum > 28'($signed({1'b0, i_setpoint_max}))) begin
                        n_setpoint = i_setpoint_max;
                    end else begin
                        n_setpoint = sp_sum[13:0];
                    end
                end
                kbsm_pkg::PG_OVERVIEW: begin
                    ov_sum = {1'b0, n_ov} + {1'b0, i_ev.ov_res};
                    if (ov_sum >= MENU_N) begin
                        ov_sum = ov_sum - MENU_N;
                    end
                    n_ov = ov_sum[3:0];
                end
                default: begin
                    row_sum = {1'b0, n_row} + {1'b0, i_ev.row_res};
                    if (row_sum >= ROWS_N) begin
                        row_sum = row_sum - ROWS_N;
                    end
                    n_row = row_sum[3:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page      <= kbsm_pkg::PG_READOUT;
            r_cursor    <= kbsm_pkg::CURSOR_RST;
            r_setpoint  <= kbsm_pkg::SETPOINT_RST;
            r_ov        <= '0;
            r_sub       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_page      <= n_page;
                r_cursor    <= n_cursor;
                r_setpoint  <= n_setpoint;
                r_ov        <= n_ov;
                r_sub       <= n_sub;
                r_row       <= n_row;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_short <= i_ev.short_press;
            r_long  <= i_ev.long_press;
            r_level <= i_ev.level;
            r_steps <= i_ev.steps;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_page             = r_page;
    assign o_digit_cursor     = r_cursor;
    assign o_setpoint_cv      = r_setpoint;
    assign o_overview_sel     = r_ov[1:0];
    assign o_open_submenu     = r_sub[1:0];
    assign o_submenu_row      = r_row[1:0];
    assign o_short_press      = r_short;
    assign o_long_press       = r_long;
    assign o_detent_steps     = r_steps;
    assign o_button_debounced = r_level;

endmodule

`default_nettype wire

/* design/kbsm_checker.sv */
// ----------------------------------------------------------------------------
// kbsm_checker
// Port-level checks for the knob and button controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "knob_button_setpoint_menu_controller_macros.svh"

module kbsm_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [1:0]         o_page,
    input wire logic [13:0]        o_setpoint_cv,
    input wire logic               o_short_press,
    input wire logic               o_long_press,
    input wire logic signed [30:0] o_detent_steps
);

    // hold a stalled result request
    `KBSM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped under stall")
    `KBSM_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_setpoint_cv) && $stable(o_detent_steps), "stalled result changed")
    // reset empties the pipe
    `KBSM_ASSERT_ALWAYS_NEXT(a_rst_empty, !i_rst_n, !o_out_valid, "result after reset")
    // a poll never brings both press kinds
    `KBSM_ASSERT_NOW(a_press_excl, o_out_valid, !(o_short_press && o_long_press), "short and long press together")
    // a long press never leaves the submenu open
    `KBSM_ASSERT_NOW(a_long_moves, o_out_valid && o_long_press && o_page == kbsm_pkg::PG_SUBLIST, 1'b0, "long press left submenu open")

endmodule

bind knob_button_setpoint_menu_controller kbsm_checker u_kbsm_checker (.*);

`default_nettype wire

/* tb/knob_button_setpoint_menu_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_button_setpoint_menu_controller_tb
// Drives polls of time, button level and quadrature count through the
// controller and predicts each result request in the bench. A short table of
// hand-picked polls comes first, then phases of randomly timed press
// sequences and knob turns under different register settings. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------

module knob_button_setpoint_menu_controller_tb;

    localparam int unsigned IDX_W          = kbsm_pkg::CFG_INDEX_W;
    localparam int unsigned DATA_W         = kbsm_pkg::CFG_DATA_W;
    localparam int unsigned QUIET_LIMIT    = 2000;
    localparam int unsigned SQUEEZE_CYCLES = 60;
    localparam int unsigned PHASE_COUNT    = 7;
    localparam int unsigned PHASE_POLLS    = 55;
    localparam int unsigned DRAIN_PAD      = 8;
    localparam int          OVERVIEW_LEN   = 4;
    localparam int          SUBMENU_LEN    = 4;

    // Setpoint step of each cursor digit: tens, ones, tenths, hundredths
    localparam longint STEP_OF_DIGIT [4] = '{1000, 100, 10, 1};

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button;
        logic [31:0] count;
    } t_poll;

    typedef struct packed {
        logic [1:0]         page;
        logic [1:0]         digit;
        logic [13:0]        setpoint;
        logic [1:0]         ov;
        logic [1:0]         sub;
        logic [1:0]         row;
        logic               short_hit;
        logic               long_hit;
        logic signed [30:0] steps;
        logic               level;
    } t_reading;

    typedef struct packed {
        t_poll    poll;
        logic     typed;
        t_reading want;
    } t_row;

    // ------------------------------------------------------------------------
    // Block signals
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [31:0]            i_now_ms;
    logic                   i_button_pressed;
    logic signed [31:0]     i_encoder_count;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [1:0]             o_page;
    logic [1:0]             o_digit_cursor;
    logic [13:0]            o_setpoint_cv;
    logic [1:0]             o_overview_sel;
    logic [1:0]             o_open_submenu;
    logic [1:0]             o_submenu_row;
    logic                   o_short_press;
    logic                   o_long_press;
    logic signed [30:0]     o_detent_steps;
    logic                   o_button_debounced;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [IDX_W-1:0]       i_cfg_index;
    logic [DATA_W-1:0]      i_cfg_data;

    knob_button_setpoint_menu_controller uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_now_ms           (i_now_ms),
        .i_button_pressed   (i_button_pressed),
        .i_encoder_count    (i_encoder_count),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_page             (o_page),
        .o_digit_cursor     (o_digit_cursor),
        .o_setpoint_cv      (o_setpoint_cv),
        .o_overview_sel     (o_overview_sel),
        .o_open_submenu     (o_open_submenu),
        .o_submenu_row      (o_submenu_row),
        .o_short_press      (o_short_press),
        .o_long_press       (o_long_press),
        .o_detent_steps     (o_detent_steps),
        .o_button_debounced (o_button_debounced),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Predicted controller: registers and state, starting from reset values
    // ------------------------------------------------------------------------
    logic [9:0]  cfg_debounce = kbsm_pkg::DEBOUNCE_MS_RST;
    logic [15:0] cfg_long     = kbsm_pkg::LONG_PRESS_MS_RST;
    logic [13:0] cfg_max      = kbsm_pkg::SETPOINT_MAX_RST;
    logic        cfg_negate   = kbsm_pkg::ENCODER_NEGATE_RST;

    logic              knob_level    = 1'b0;
    logic [31:0]       edge_ms       = '0;
    logic [31:0]       hold_start_ms = '0;
    logic              long_done     = 1'b0;
    logic [31:0]       last_count    = '0;
    longint            detent_rem    = 0;
    kbsm_pkg::t_page   cur_page      = kbsm_pkg::PG_READOUT;
    logic [1:0]        cur_digit     = kbsm_pkg::CURSOR_RST;
    longint            cur_setpoint  = 1250;
    logic [1:0]        cur_ov        = '0;
    logic [1:0]        cur_sub       = '0;
    logic [1:0]        cur_row       = '0;

    // Readings still owed by the block, oldest first
    t_reading    pending_readings[$];
    t_row        plan[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned quiet_cycles   = 0;
    bit          squeezed       = 1'b0;
    bit          steady_phase   = 1'b0;

    // Random press sequence generator
    logic [31:0] gen_t     = '0;
    logic [31:0] gen_until = '0;
    logic        gen_level = 1'b0;
    logic [31:0] gen_count = '0;

    // Apply one poll to the predicted controller and return its reading.
    // The button is handled before the rotation.
    function automatic t_reading advance_knob(input t_poll p);
        t_reading    r;
        logic [31:0] diff;
        longint      delta;
        longint      total;
        longint      steps;
        longint      sp;
        longint      wrapped;
        r = '0;
        if (p.button != knob_level && (p.now_ms - edge_ms) > 32'(cfg_debounce)) begin
            edge_ms    = p.now_ms;
            knob_level = p.button;
            if (p.button) begin
                hold_start_ms = p.now_ms;
                long_done     = 1'b0;
            end else if (!long_done) begin
                // a release before the long press fired is a short press
                r.short_hit = 1'b1;
                if (cur_page == kbsm_pkg::PG_READOUT) begin
                    cur_digit = cur_digit + 2'd1;
                end else if (cur_page == kbsm_pkg::PG_OVERVIEW) begin
                    cur_sub  = cur_ov;
                    cur_row  = '0;
                    cur_page = kbsm_pkg::PG_SUBLIST;
                end
            end
        end
        // fire once per hold; the release after it is swallowed above
        if (knob_level && !long_done && (p.now_ms - hold_start_ms) >= 32'(cfg_long)) begin
            long_done  = 1'b1;
            r.long_hit = 1'b1;
            case (cur_page)
                kbsm_pkg::PG_READOUT: begin
                    cur_ov   = '0;
                    cur_page = kbsm_pkg::PG_OVERVIEW;
                end
                kbsm_pkg::PG_OVERVIEW: cur_page = kbsm_pkg::PG_READOUT;
                default:               cur_page = kbsm_pkg::PG_OVERVIEW;
            endcase
        end

        // count delta wraps as a signed 32-bit value, the rest is wide
        diff       = p.count - last_count;
        last_count = p.count;
        delta      = $signed(diff);
        if (cfg_negate) begin
            delta = -delta;
        end
        total      = detent_rem + delta;
        steps      = total / 4;
        detent_rem = total - steps * 4;
        if (steps != 0) begin
            case (cur_page)
                kbsm_pkg::PG_READOUT: begin
                    sp = cur_setpoint + steps * STEP_OF_DIGIT[cur_digit];
                    if (sp < 0) begin
                        sp = 0;
                    end
                    if (sp > longint'(cfg_max)) begin
                        sp = longint'(cfg_max);
                    end
                    cur_setpoint = sp;
                end
                kbsm_pkg::PG_OVERVIEW: begin
                    wrapped = (longint'(cur_ov) + steps) % OVERVIEW_LEN;
                    if (wrapped < 0) begin
                        wrapped = wrapped + OVERVIEW_LEN;
                    end
                    cur_ov = 2'(wrapped);
                end
                default: begin
                    wrapped = (longint'(cur_row) + steps) % SUBMENU_LEN;
                    if (wrapped < 0) begin
                        wrapped = wrapped + SUBMENU_LEN;
                    end
                    cur_row = 2'(wrapped);
                end
            endcase
        end

        r.page     = cur_page;
        r.digit    = cur_digit;
        r.setpoint = 14'(cur_setpoint);
        r.ov       = cur_ov;
        r.sub      = cur_sub;
        r.row      = cur_row;
        r.steps    = 31'(steps);
        r.level    = knob_level;
        return r;
    endfunction

    function automatic t_reading reading(input kbsm_pkg::t_page pg, input int digit,
                                         input int sp, input int ov, input int sub,
                                         input int row, input bit sh, input bit lg,
                                         input int steps, input bit lvl);
        t_reading r;
        r.page      = pg;
        r.digit     = 2'(digit);
        r.setpoint  = 14'(sp);
        r.ov        = 2'(ov);
        r.sub       = 2'(sub);
        r.row       = 2'(row);
        r.short_hit = sh;
        r.long_hit  = lg;
        r.steps     = 31'(steps);
        r.level     = lvl;
        return r;
    endfunction

    task automatic add_row(input logic [31:0] now, input logic btn, input logic [31:0] count,
                           input logic typed, input t_reading want);
        t_row row;
        row.poll.now_ms = now;
        row.poll.button = btn;
        row.poll.count  = count;
        row.typed       = typed;
        row.want        = want;
        plan.push_back(row);
    endtask

    // Mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Next random poll: press and release sequences timed against the current
    // debounce and long-press settings, with noise on the level, the time and
    // the count.
    function automatic t_poll next_poll();
        t_poll       p;
        int unsigned unit;
        int unsigned lo;
        int unsigned hold_ms;
        int unsigned roll;
        unit  = (32'(cfg_long) + 32'(cfg_debounce)) / 8 + 1;
        gen_t = gen_t + $urandom_range(1, unit);
        roll  = $urandom_range(0, 99);
        if (roll < 4) begin
            gen_t     = $urandom();
            gen_until = gen_t;
        end
        if ($signed(gen_t - gen_until) >= 0) begin
            gen_level = !gen_level;
            lo        = 32'(cfg_debounce) + 1;
            if (!gen_level) begin
                hold_ms = $urandom_range(lo, lo + 4 * unit);
            end else if ($urandom_range(0, 1) && 32'(cfg_long) > lo) begin
                hold_ms = $urandom_range(lo, 32'(cfg_long) - 1);
            end else begin
                hold_ms = (32'(cfg_long) > lo) ? 32'(cfg_long) : lo;
                hold_ms = $urandom_range(hold_ms, hold_ms + 32'(cfg_long) / 2 + lo);
            end
            gen_until = gen_t + hold_ms;
        end
        p.now_ms = gen_t;
        p.button = (roll >= 4 && roll < 12) ? 1'($urandom_range(0, 1)) : gen_level;

        roll = $urandom_range(0, 99);
        if (roll >= 97) begin
            gen_count = $urandom();
        end else if (roll >= 55) begin
            gen_count = gen_count + $urandom_range(0, 24) - 12;
        end
        p.count = gen_count;
        return p;
    endfunction

    // Offer one poll, hold it until taken, then log what it should produce
    task automatic offer_poll(input t_poll p, input logic typed, input t_reading want);
        int unsigned gap;
        t_reading    predicted;
        gap = steady_phase ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_now_ms         <= p.now_ms;
        i_button_pressed <= p.button;
        i_encoder_count  <= p.count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = advance_knob(p);
        pending_readings.push_back(typed ? want : predicted);
    endtask

    // Drop the poll valid and wait for every owed reading
    task automatic drain_readings();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            kbsm_pkg::CFG_DEBOUNCE_MS:    cfg_debounce = val[9:0];
            kbsm_pkg::CFG_LONG_PRESS_MS:  cfg_long     = val[15:0];
            kbsm_pkg::CFG_SETPOINT_MAX:   cfg_max      = val[13:0];
            kbsm_pkg::CFG_ENCODER_NEGATE: cfg_negate   = val[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed table, then randomised phases
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned deb_set [PHASE_COUNT];
        int unsigned long_set [PHASE_COUNT];
        int unsigned max_set [PHASE_COUNT];
        int unsigned flip_set [PHASE_COUNT];
        t_reading    none;

        deb_set          = '{0, 1023, 5, 20, 0, 1023, 0};
        long_set         = '{0, 65535, 40, 200, 1, 2000, 0};
        max_set          = '{9999, 0, 9999, 1234, 500, 9999, 0};
        flip_set         = '{0, 1, 1, 0, 1, 0, 0};
        none             = '0;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_now_ms         <= '0;
        i_button_pressed <= 1'b0;
        i_encoder_count  <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;

        // Directed polls under reset settings (lockout 30, long 600, max 3000,
        // negated count). Readings easy to see are written out in full.
        add_row(32'd0, 1'b0, 32'h0000_0000, 1'b1,
                reading(kbsm_pkg::PG_READOUT, 3, 1250, 0, 0, 0, 0, 0, 0, 0));
        // one detent on the hundredths digit
        add_row(32'd10, 1'b0, 32'hFFFF_FFFC, 1'b1,
                reading(kbsm_pkg::PG_READOUT, 3, 1251, 0, 0, 0, 0, 0, 1, 0));
        // press inside the lockout is ignored
        add_row(32'd20, 1'b1, 32'hFFFF_FFFC, 1'b1,
                reading(kbsm_pkg::PG_READOUT, 3, 1251, 0, 0, 0, 0, 0, 0, 0));
        add_row(32'd31, 1'b1, 32'hFFFF_FFFC, 1'b1,
                reading(kbsm_pkg::PG_READOUT, 3, 1251, 0, 0, 0, 0, 0, 0, 1));
        // short press moves the cursor round to the tens digit
        add_row(32'd100, 1'b0, 32'hFFFF_FFFC, 1'b1,
                reading(kbsm_pkg::PG_READOUT, 0, 1251, 0, 0, 0, 1, 0, 0, 0));
        // huge count jump: setpoint clamps at the top
        add_row(32'd200, 1'b0, 32'h7FFF_FFFF, 1'b1,
                reading(kbsm_pkg::PG_READOUT, 0, 3000, 0, 0, 0, 0, 0, 536870911, 0));
        add_row(32'd300, 1'b0, 32'h8000_0000, 1'b0, none);
        add_row(32'd400, 1'b1, 32'h8000_0000, 1'b0, none);
        add_row(32'd999, 1'b1, 32'h8000_0000, 1'b0, none);
        // long press fires exactly at the threshold and opens the overview
        add_row(32'd1000, 1'b1, 32'h8000_0000, 1'b1,
                reading(kbsm_pkg::PG_OVERVIEW, 0, 3000, 0, 0, 0, 0, 1, 0, 1));
        // release swallowed, highlight moves forward
        add_row(32'd1100, 1'b0, 32'h7FFF_FFF8, 1'b0, none);
        // highlight moves back past zero
        add_row(32'd1200, 1'b1, 32'h8000_000C, 1'b0, none);
        add_row(32'd1300, 1'b0, 32'h8000_000C, 1'b0, none);
        add_row(32'd1400, 1'b1, 32'h8000_0010, 1'b0, none);
        // short press inside the submenu does nothing
        add_row(32'd1450, 1'b0, 32'h8000_0010, 1'b0, none);
        add_row(32'd1500, 1'b1, 32'h8000_0013, 1'b0, none);
        add_row(32'd2100, 1'b1, 32'h8000_0013, 1'b0, none);
        add_row(32'd2200, 1'b0, 32'h8000_0011, 1'b0, none);
        add_row(32'd2300, 1'b1, 32'h8000_0011, 1'b0, none);
        add_row(32'd2900, 1'b1, 32'h8000_0011, 1'b0, none);
        // back on the main page: large turn the other way clamps at zero
        add_row(32'd3000, 1'b0, 32'h8000_0141, 1'b0, none);
        // time wraps between press and release; count jumps by half the range
        add_row(32'hFFFF_FFE0, 1'b1, 32'h8000_0141, 1'b0, none);
        add_row(32'h0000_0010, 1'b0, 32'h0000_0141, 1'b0, none);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            offer_poll(plan[i].poll, plan[i].typed, plan[i].want);
        end

        gen_t     = 32'd5000;
        gen_count = 32'h0000_0141;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            drain_readings();
            // let the pipeline fall quiet before touching registers
            repeat (DRAIN_PAD) @(posedge i_clk);
            if (ph == PHASE_COUNT - 1) begin
                deb_set[ph]  = $urandom_range(0, 1023);
                long_set[ph] = $urandom_range(0, 3000);
                max_set[ph]  = $urandom_range(0, 9999);
                flip_set[ph] = $urandom_range(0, 1);
            end
            // an unknown index first, which must leave everything alone
            write_reg(kbsm_pkg::CFG_ENCODER_NEGATE + IDX_W'($urandom_range(1, 252)),
                      DATA_W'($urandom()));
            write_reg(kbsm_pkg::CFG_DEBOUNCE_MS, DATA_W'(deb_set[ph]));
            write_reg(kbsm_pkg::CFG_LONG_PRESS_MS, DATA_W'(long_set[ph]));
            write_reg(kbsm_pkg::CFG_SETPOINT_MAX, DATA_W'(max_set[ph]));
            write_reg(kbsm_pkg::CFG_ENCODER_NEGATE, DATA_W'(flip_set[ph]));
            i_cfg_valid <= 1'b0;

            steady_phase = (ph == 2);
            gen_level    = knob_level;
            if (ph % 2 == 1) begin
                // start just below the wrap of the millisecond clock
                gen_t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            end
            gen_until = gen_t;
            for (int n = 0; n < PHASE_POLLS; n++) begin
                offer_poll(next_poll(), 1'b0, none);
            end
        end

        drain_readings();
        repeat (DRAIN_PAD) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side stall: random holds, plus one long squeeze so the block
    // fills up and pushes back on the poll side
    // ------------------------------------------------------------------------
    initial begin : result_stall
        int unsigned hold_cycles;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!squeezed && results_seen >= 60) begin
                squeezed = 1'b1;
                i_out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end else begin
                hold_cycles = steady_phase ? 0 : pick_gap();
                if (hold_cycles != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold_cycles) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Checking: every accepted result request against the oldest reading owed
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_readings.size() == 0) begin
                $error("result request with no poll outstanding");
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                compare_field("page", want.page, o_page);
                compare_field("digit_cursor", want.digit, o_digit_cursor);
                compare_field("setpoint_cv", want.setpoint, o_setpoint_cv);
                compare_field("overview_sel", want.ov, o_overview_sel);
                compare_field("open_submenu", want.sub, o_open_submenu);
                compare_field("submenu_row", want.row, o_submenu_row);
                compare_field("short_press", want.short_hit, o_short_press);
                compare_field("long_press", want.long_hit, o_long_press);
                compare_field("detent_steps", want.steps, o_detent_steps);
                compare_field("button_debounced", want.level, o_button_debounced);
            end
        end
    end

    // Give up once nothing has moved on any channel for too long
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
